// File: sv/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
`default_nettype none
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Command from the byte packer to the compression engine.
	typedef enum logic [1:0] {
		CMD_BLOCK  = 2'd0,
		CMD_FINAL  = 2'd1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic [511:0] block;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ROUND = 2'd1,
		ST_ADD   = 2'd2,
		ST_EMIT  = 2'd3
	} core_state_t;

	typedef enum logic [1:0] {
		PK_TAKE  = 2'd0,
		PK_PAD   = 2'd1,
		PK_LEN   = 2'd2
	} pack_state_t;

	localparam int unsigned CmdQueueDepth = 2;

	localparam logic [255:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

// File: sv/sha256_packer.sv
// Front end: packs message bytes into blocks and appends the padding and length.
`default_nettype none
module sha256_packer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire sha256_pkg::in_item_t in_item,
	output logic                      cmd_valid,
	input  wire logic                 cmd_ready,
	output sha256_pkg::cmd_t          cmd
);
	import sha256_pkg::*;

	pack_state_t  state_q, state_d;
	logic [511:0] block_q;
	logic [5:0]   fill_q;
	logic [60:0]  msg_bytes_q;
	logic         last_pend_q;

	logic         byte_take;
	logic [7:0]   byte_val;
	logic         block_done;
	logic [63:0]  bit_len;

	assign bit_len = {msg_bytes_q, 3'b000};
	// A block leaves when its 64th byte lands; the packer stalls if the queue is full.
	assign block_done = byte_take && (fill_q == 6'd63);

	always_comb begin
		state_d   = state_q;
		full      = 1'b1;
		byte_take = 1'b0;
		byte_val  = 8'h00;
		cmd_valid = 1'b0;
		cmd.kind  = CMD_BLOCK;
		cmd.block = block_q;
		unique case (state_q)
			PK_TAKE: begin
				full = (fill_q == 6'd63) && !cmd_ready;
				if (push && !full && in_item.has_byte) begin
					byte_take = 1'b1;
					byte_val  = in_item.data_byte;
				end
				if (push && !full && in_item.last_byte)
					state_d = PK_PAD;
			end
			PK_PAD: begin
				// First padding byte is 0x80, the rest zero until byte 56.
				if (fill_q != 6'd56 || last_pend_q) begin
					if (!(fill_q == 6'd63 && !cmd_ready)) begin
						byte_take = 1'b1;
						byte_val  = last_pend_q ? 8'h80 : 8'h00;
					end
				end else begin
					state_d = PK_LEN;
				end
			end
			PK_LEN: begin
				cmd_valid = 1'b1;
				cmd.kind  = CMD_FINAL;
				cmd.block = {block_q[511:64], bit_len};
				if (cmd_ready)
					state_d = PK_TAKE;
			end
			default: state_d = PK_TAKE;
		endcase
		if (block_done) begin
			cmd_valid = 1'b1;
			cmd.kind  = CMD_BLOCK;
			cmd.block = {block_q[511:8], byte_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= PK_TAKE;
			fill_q      <= '0;
			msg_bytes_q <= '0;
			last_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (byte_take)
				fill_q <= fill_q + 6'd1;
			if (state_q == PK_TAKE && byte_take)
				msg_bytes_q <= msg_bytes_q + 61'd1;
			if (state_q == PK_TAKE && push && !full && in_item.last_byte)
				last_pend_q <= 1'b1;
			else if (state_q == PK_PAD && byte_take)
				last_pend_q <= 1'b0;
			if (state_q == PK_LEN && cmd_ready) begin
				fill_q      <= '0;
				msg_bytes_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take)
			block_q[(6'd63 - fill_q) * 8 +: 8] <= byte_val;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PK_LEN |-> fill_q == 6'd56)
		else $error("length block issued at wrong fill");
	assert property (@(posedge clk) disable iff (!arst_n)
		block_done |-> cmd_ready)
		else $error("block completed while queue full");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != PK_TAKE |-> full)
		else $error("input open during padding");
endmodule
`default_nettype wire

// File: sv/sha256_cmd_queue.sv
// Short command queue between the packer and the compression engine.
`default_nettype none
module sha256_cmd_queue #(
	parameter int unsigned Depth = sha256_pkg::CmdQueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire sha256_pkg::cmd_t wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output sha256_pkg::cmd_t      rd_data
);
	import sha256_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;
	logic          do_wr, do_rd;

	assign wr_ready = (count_q != (AW+1)'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= bump(wptr_q);
			if (do_rd)
				rptr_q <= bump(rptr_q);
			count_q <= count_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(Depth))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !do_rd)
		else $error("read from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> count_q == $past(count_q) + (AW+1)'(1))
		else $error("count lost a write");
endmodule
`default_nettype wire

// File: sv/sha256_core.sv
// Back end: 64-round compression, chaining update and digest output register.
`default_nettype none
module sha256_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cmd_valid,
	output logic                       cmd_ready,
	input  wire sha256_pkg::cmd_t      cmd,
	output logic                       empty,
	input  wire logic                  pop,
	output sha256_pkg::out_item_t      out_item
);
	import sha256_pkg::*;

	core_state_t  state_q, state_d;
	logic [31:0]  w_q [16];
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [5:0]   round_q;
	logic         final_q;
	logic [2:0]   emit_q;

	logic [31:0]  w_cur, w_new, s0, s1, t1, t2, ch, maj, se, sa;

	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		// The window slides each round; rounds 0..15 read slot 0, later ones use w_new.
		w_cur = (round_q < 6'd16) ? w_q[0] : w_new;
		se    = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		sa    = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + se + ch + round_k(round_q) + w_cur;
		t2    = sa + maj;
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		empty     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid)
					state_d = ST_ROUND;
			end
			ST_ROUND: if (round_q == 6'd63) state_d = ST_ADD;
			ST_ADD:   state_d = final_q ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				empty = 1'b0;
				if (pop && emit_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			emit_q  <= '0;
			final_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= INIT_H[(7 - i) * 32 +: 32];
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_valid) begin
				final_q <= (cmd.kind == CMD_FINAL);
				round_q <= '0;
			end
			if (state_q == ST_ROUND)
				round_q <= round_q + 6'd1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= h_q[i] + v_q[i];
				emit_q <= '0;
			end
			if (state_q == ST_EMIT && pop) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7)
					for (int i = 0; i < 8; i++)
						h_q[i] <= INIT_H[(7 - i) * 32 +: 32];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= cmd.block[(15 - i) * 32 +: 32];
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign out_item.digest_word = h_q[emit_q];
	assign out_item.word_index  = emit_q;
	assign out_item.last_word   = (emit_q == 3'd7);

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> round_q == 6'd0)
		else $error("round counter out of step");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> final_q)
		else $error("digest shown for a non-final block");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> empty)
		else $error("command taken during digest output");
endmodule
`default_nettype wire

// File: sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
// Input channel (push/full): one in_item per transfer carrying a message byte
// (has_byte), and last_byte to close the message. A transfer with last_byte set
// and has_byte clear ends the message without a byte; with no earlier bytes it
// hashes the empty message.
// Output channel (empty/pop): after a message ends, eight digest words appear,
// most significant first, word_index 0..7, last_word set on the eighth.
// Bytes are taken one per cycle while full is low. Each full 64-byte block
// goes through a short command queue to the compression engine, which loads
// it, runs the 64 rounds and then the chaining add; this engine sets the
// sustained rate, and the padding blocks at message end come on top of it.
// Padding is inserted one byte per cycle with full held high; full also rises
// and padding pauses when the 64th byte of a block is due and the queue is full.
// With the engine idle, the first digest word appears once the final block, which
// holds the length, has been compressed and added; the padding needs one more
// block when k, the message bytes in the final block, is 56 or more.
// The digest is held until all eight words are popped; a stalled receiver
// stalls the engine and, once the queue fills, the input.
// Reset clears all control state and loads the standard initial hash values.
`default_nettype none
module sha256_stream_hasher #(
	parameter int unsigned QueueDepth = sha256_pkg::CmdQueueDepth
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire sha256_pkg::in_item_t  in_item,
	output logic                       empty,
	input  wire logic                  pop,
	output sha256_pkg::out_item_t      out_item
);
	import sha256_pkg::*;

	logic pk_valid, pk_ready, q_valid, q_ready;
	cmd_t pk_cmd, q_cmd;

	sha256_packer u_packer (
		.clk, .arst_n, .push, .full, .in_item,
		.cmd_valid(pk_valid), .cmd_ready(pk_ready), .cmd(pk_cmd));

	sha256_cmd_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(pk_valid), .wr_ready(pk_ready), .wr_data(pk_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd));

	sha256_core u_core (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.empty, .pop, .out_item);
endmodule
`default_nettype wire
